// ===== sv/duration_to_decimal_text_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the duration text formatter
// Clocked, reset-gated property wrappers used by the formatter RTL.
// ----------------------------------------------------------------------------
`ifndef DURATION_TO_DECIMAL_TEXT_DEFINES_SVH
`define DURATION_TO_DECIMAL_TEXT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DTDT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtdt assertion failed");

// Next-cycle implication, checked out of reset.
`define DTDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtdt assertion failed");

`endif

// ===== sv/dtdt_pkg.sv =====
// ----------------------------------------------------------------------------
// dtdt_pkg
// Constants and the shift-add-3 step used by the duration text formatter.
// ----------------------------------------------------------------------------
package dtdt_pkg;

    localparam int SEC_W      = 64;
    localparam int NANO_W     = 31;
    localparam int NS_MAG_W   = 30;
    localparam int SEC_DIGITS = 20;
    localparam int NS_DIGITS  = 9;
    localparam int BCD_W      = SEC_DIGITS * 4;
    localparam int NS_BCD_W   = NS_DIGITS * 4;
    localparam int CHAR_W     = 8;

    localparam logic [NANO_W-1:0] NANO_LIMIT = 31'd999999999;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_S     = 8'h73;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

    typedef logic [BCD_W-1:0] t_bcd;

    // One double-dabble iteration: correct every digit >= 5, then shift in one bit.
    function automatic t_bcd dd_step(input t_bcd bcd, input logic bit_in);
        t_bcd adj;
        adj = bcd;
        for (int d = 0; d < SEC_DIGITS; d++) begin
            if (bcd[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

endpackage

// ===== sv/duration_to_decimal_text.sv =====
// ----------------------------------------------------------------------------
// duration_to_decimal_text
// Formats a signed seconds/nanoseconds duration as ASCII text, one
// character per output transaction, e.g. "-12.500s".
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one duration. Output
//   channel (o_out_valid / i_out_ready) returns its text one character per
//   transaction; o_last_char flags the closing 's'.
//   One shared shift-add-3 unit converts binary to BCD one bit per cycle:
//   first the nanoseconds, then the seconds. Leading zero digits of the
//   seconds are then dropped at one per cycle (up to 19). Characters
//   (2 to 31) follow at one per cycle while the receiver takes them.
//   o_in_ready is high only between items. The output register lets the
//   final 's' wait for the receiver while the next duration is accepted.
//   A stalled receiver freezes character generation; nothing is dropped.
//   Reset (i_rst_n low, synchronous) empties the output register and
//   returns the sequencer to idle.
// ----------------------------------------------------------------------------
`include "duration_to_decimal_text_defines.svh"

module duration_to_decimal_text (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [dtdt_pkg::SEC_W-1:0]   i_whole_seconds,
    input  logic signed [dtdt_pkg::NANO_W-1:0]  i_nano_part,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [dtdt_pkg::CHAR_W-1:0]         o_text_char,
    output logic                                o_last_char
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_CONV_NS  = 4'd1;
    localparam logic [3:0] ST_CONV_SEC = 4'd2;
    localparam logic [3:0] ST_SIGN     = 4'd3;
    localparam logic [3:0] ST_SKIP     = 4'd4;
    localparam logic [3:0] ST_SEC      = 4'd5;
    localparam logic [3:0] ST_DOT      = 4'd6;
    localparam logic [3:0] ST_FRAC     = 4'd7;
    localparam logic [3:0] ST_SUFFIX   = 4'd8;

    localparam int BCD_W    = dtdt_pkg::BCD_W;
    localparam int NS_BCD_W = dtdt_pkg::NS_BCD_W;
    localparam int SEC_W    = dtdt_pkg::SEC_W;
    localparam int NANO_W   = dtdt_pkg::NANO_W;
    localparam int NS_MAG_W = dtdt_pkg::NS_MAG_W;

    logic [3:0]                  r_state, n_state;
    logic [6:0]                  r_cnt, n_cnt;       // conversion bit counter
    logic [4:0]                  r_dcnt, n_dcnt;     // seconds digits left
    logic [3:0]                  r_fcnt, n_fcnt;     // fraction digits left
    logic [SEC_W-1:0]            r_bin, n_bin;       // bits fed to the shared unit
    logic [SEC_W-1:0]            r_sec_mag, n_sec_mag;
    dtdt_pkg::t_bcd              r_acc, n_acc;
    logic [NS_BCD_W-1:0]         r_ns_bcd, n_ns_bcd;
    logic                        r_neg, n_neg;
    logic                        r_ns_nz, n_ns_nz;
    logic                        r_out_valid, n_out_valid;
    logic [dtdt_pkg::CHAR_W-1:0] r_char, n_char;
    logic                        r_last, n_last;

    dtdt_pkg::t_bcd              w_step;
    logic                        w_accept;
    logic                        w_adv;
    logic                        w_sec_neg;
    logic                        w_ns_neg;
    logic [SEC_W-1:0]            w_sec_mag;
    logic [NANO_W-1:0]           w_ns_raw;
    logic [NS_MAG_W-1:0]         w_ns_mag;
    logic [3:0]                  w_flen;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_adv       = !r_out_valid || i_out_ready;
    assign w_step      = dtdt_pkg::dd_step(r_acc, r_bin[SEC_W-1]);

    assign w_sec_neg   = i_whole_seconds[SEC_W-1];
    assign w_ns_neg    = i_nano_part[NANO_W-1];
    assign w_sec_mag   = w_sec_neg ? (~i_whole_seconds + 64'd1) : i_whole_seconds;
    assign w_ns_raw    = w_ns_neg ? (~i_nano_part + 31'd1) : i_nano_part;
    assign w_ns_mag    = (w_ns_raw > dtdt_pkg::NANO_LIMIT) ?
                         dtdt_pkg::NANO_LIMIT[NS_MAG_W-1:0] : w_ns_raw[NS_MAG_W-1:0];

    // trim trailing zero triples, keep at least three digits
    assign w_flen = (r_ns_bcd[11:0] != 12'd0)  ? 4'd9 :
                    (r_ns_bcd[23:12] != 12'd0) ? 4'd6 : 4'd3;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_dcnt      = r_dcnt;
        n_fcnt      = r_fcnt;
        n_bin       = r_bin;
        n_sec_mag   = r_sec_mag;
        n_acc       = r_acc;
        n_ns_bcd    = r_ns_bcd;
        n_neg       = r_neg;
        n_ns_nz     = r_ns_nz;
        n_char      = r_char;
        n_last      = r_last;
        n_out_valid = r_out_valid && !i_out_ready;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_neg     = w_sec_neg || w_ns_neg;
                    n_ns_nz   = (w_ns_mag != '0);
                    n_sec_mag = w_sec_mag;
                    n_bin     = {w_ns_mag, {(SEC_W-NS_MAG_W){1'b0}}};
                    n_acc     = '0;
                    n_cnt     = 7'(NS_MAG_W);
                    n_state   = ST_CONV_NS;
                end
            end
            ST_CONV_NS: begin
                n_acc = w_step;
                n_bin = {r_bin[SEC_W-2:0], 1'b0};
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    n_ns_bcd = w_step[NS_BCD_W-1:0];
                    n_acc    = '0;
                    n_bin    = r_sec_mag;
                    n_cnt    = 7'(SEC_W);
                    n_state  = ST_CONV_SEC;
                end
            end
            ST_CONV_SEC: begin
                n_acc = w_step;
                n_bin = {r_bin[SEC_W-2:0], 1'b0};
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    n_dcnt  = 5'(dtdt_pkg::SEC_DIGITS);
                    n_state = r_neg ? ST_SIGN : ST_SKIP;
                end
            end
            ST_SIGN: begin
                if (w_adv) begin
                    n_char      = dtdt_pkg::CH_MINUS;
                    n_last      = 1'b0;
                    n_out_valid = 1'b1;
                    n_state     = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if ((r_acc[BCD_W-1 -: 4] == 4'd0) && (r_dcnt > 5'd1)) begin
                    n_acc  = {r_acc[BCD_W-5:0], 4'd0};
                    n_dcnt = r_dcnt - 5'd1;
                end else begin
                    n_state = ST_SEC;
                end
            end
            ST_SEC: begin
                if (w_adv) begin
                    n_char      = dtdt_pkg::CH_ZERO | {4'd0, r_acc[BCD_W-1 -: 4]};
                    n_last      = 1'b0;
                    n_out_valid = 1'b1;
                    n_acc       = {r_acc[BCD_W-5:0], 4'd0};
                    n_dcnt      = r_dcnt - 5'd1;
                    if (r_dcnt == 5'd1) begin
                        n_state = r_ns_nz ? ST_DOT : ST_SUFFIX;
                    end
                end
            end
            ST_DOT: begin
                if (w_adv) begin
                    n_char      = dtdt_pkg::CH_DOT;
                    n_last      = 1'b0;
                    n_out_valid = 1'b1;
                    n_fcnt      = w_flen;
                    n_state     = ST_FRAC;
                end
            end
            ST_FRAC: begin
                if (w_adv) begin
                    n_char      = dtdt_pkg::CH_ZERO | {4'd0, r_ns_bcd[NS_BCD_W-1 -: 4]};
                    n_last      = 1'b0;
                    n_out_valid = 1'b1;
                    n_ns_bcd    = {r_ns_bcd[NS_BCD_W-5:0], 4'd0};
                    n_fcnt      = r_fcnt - 4'd1;
                    if (r_fcnt == 4'd1) begin
                        n_state = ST_SUFFIX;
                    end
                end
            end
            ST_SUFFIX: begin
                if (w_adv) begin
                    n_char      = dtdt_pkg::CH_S;
                    n_last      = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_dcnt    <= n_dcnt;
        r_fcnt    <= n_fcnt;
        r_bin     <= n_bin;
        r_sec_mag <= n_sec_mag;
        r_acc     <= n_acc;
        r_ns_bcd  <= n_ns_bcd;
        r_neg     <= n_neg;
        r_ns_nz   <= n_ns_nz;
        r_char    <= n_char;
        r_last    <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_text_char = r_char;
    assign o_last_char = r_last;

    `DTDT_ASSERT_NEXT(a_accept_starts_conv, i_clk, i_rst_n, w_accept,
        (r_state == ST_CONV_NS) && !o_in_ready)
    `DTDT_ASSERT_NOW(a_last_is_s, i_clk, i_rst_n, o_out_valid && o_last_char,
        o_text_char == dtdt_pkg::CH_S)
    `DTDT_ASSERT_NOW(a_sec_digits_left, i_clk, i_rst_n,
        (r_state == ST_SEC) || (r_state == ST_SKIP), r_dcnt != 5'd0)
    `DTDT_ASSERT_NOW(a_frac_len, i_clk, i_rst_n, r_state == ST_FRAC,
        (r_fcnt != 4'd0) && (r_fcnt <= 4'd9))

endmodule

// ===== sim/duration_to_decimal_text_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duration_to_decimal_text_checker
// Watches both channels of the duration text formatter. For every accepted
// duration it builds the expected character stream. Each character the
// block hands over is then compared with the oldest expected one.
// ----------------------------------------------------------------------------
module duration_to_decimal_text_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic signed [dtdt_pkg::SEC_W-1:0]   i_whole_seconds,
    input  logic signed [dtdt_pkg::NANO_W-1:0]  i_nano_part,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic [dtdt_pkg::CHAR_W-1:0]         i_text_char,
    input  logic                                i_last_char,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    typedef struct packed {
        logic [dtdt_pkg::CHAR_W-1:0] text_char;
        logic                        last_char;
    } t_text_beat;

    t_text_beat expected_text[$];
    int         fail_total = 0;

    function automatic void push_char(input logic [dtdt_pkg::CHAR_W-1:0] ch,
                                      input logic last);
        t_text_beat beat;
        beat.text_char = ch;
        beat.last_char = last;
        expected_text.insert(expected_text.size(), beat);
    endfunction

    // Expected text of one duration: sign, seconds digits, trimmed fraction, 's'.
    function automatic void predict_text(input logic [dtdt_pkg::SEC_W-1:0] secs,
                                         input logic [dtdt_pkg::NANO_W-1:0] nanos);
        logic [dtdt_pkg::SEC_W-1:0]  sec_mag;
        logic [dtdt_pkg::NANO_W-1:0] ns_mag;
        logic [dtdt_pkg::SEC_W-1:0]  rest;
        logic [dtdt_pkg::CHAR_W-1:0] sec_digits[$];
        logic [dtdt_pkg::CHAR_W-1:0] frac[dtdt_pkg::NS_DIGITS];
        int                          keep_digits;

        // Unsigned negation gives 2^63 for the most negative seconds
        sec_mag = secs[dtdt_pkg::SEC_W-1] ? -secs : secs;
        ns_mag  = nanos[dtdt_pkg::NANO_W-1] ? -nanos : nanos;
        if (ns_mag > dtdt_pkg::NANO_LIMIT) begin
            ns_mag = dtdt_pkg::NANO_LIMIT;
        end

        if (secs[dtdt_pkg::SEC_W-1] || nanos[dtdt_pkg::NANO_W-1]) begin
            push_char(dtdt_pkg::CH_MINUS, 1'b0);
        end

        rest = sec_mag;
        do begin
            sec_digits.push_front(dtdt_pkg::CH_ZERO + dtdt_pkg::CHAR_W'(rest % 10));
            rest = rest / 10;
        end while (rest != 0);
        foreach (sec_digits[k]) begin
            push_char(sec_digits[k], 1'b0);
        end

        if (ns_mag != 0) begin
            rest = dtdt_pkg::SEC_W'(ns_mag);
            for (int k = dtdt_pkg::NS_DIGITS - 1; k >= 0; k--) begin
                frac[k] = dtdt_pkg::CH_ZERO + dtdt_pkg::CHAR_W'(rest % 10);
                rest    = rest / 10;
            end
            keep_digits = dtdt_pkg::NS_DIGITS;
            while (keep_digits > 3 && frac[keep_digits-1] == dtdt_pkg::CH_ZERO &&
                   frac[keep_digits-2] == dtdt_pkg::CH_ZERO &&
                   frac[keep_digits-3] == dtdt_pkg::CH_ZERO) begin
                keep_digits -= 3;
            end
            push_char(dtdt_pkg::CH_DOT, 1'b0);
            for (int k = 0; k < keep_digits; k++) begin
                push_char(frac[k], 1'b0);
            end
        end

        push_char(dtdt_pkg::CH_S, 1'b1);
    endfunction

    always @(posedge i_clk) begin : watch
        t_text_beat want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                predict_text(i_whole_seconds, i_nano_part);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_text.size() == 0) begin
                    if (fail_total < 10) begin
                        $display("%0t: unexpected char %h last %b, nothing pending",
                                 $realtime, i_text_char, i_last_char);
                    end
                    fail_total++;
                end else begin
                    want = expected_text.pop_front();
                    if (want.text_char !== i_text_char || want.last_char !== i_last_char) begin
                        if (fail_total < 10) begin
                            $display("%0t: char expected %h last %b, got %h last %b",
                                     $realtime, want.text_char, want.last_char,
                                     i_text_char, i_last_char);
                        end
                        fail_total++;
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_text.size();
    end

endmodule

// ===== sim/duration_to_decimal_text_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duration_to_decimal_text_test
// Drives durations into the formatter: a directed set of edge values, then
// random phases with sender gaps and receiver stalls, one long receiver
// hold-off and drains between phases. Checking is done by the checker.
// ----------------------------------------------------------------------------
module duration_to_decimal_text_test;

    localparam int SEC_W            = dtdt_pkg::SEC_W;
    localparam int NANO_W           = dtdt_pkg::NANO_W;
    localparam int CHAR_W           = dtdt_pkg::CHAR_W;
    localparam int RANDOM_PER_PHASE = 95;
    localparam int HOLD_CYCLES      = 800;
    localparam int STUCK_LIMIT      = 4000;
    localparam int TAIL_CYCLES      = 160;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic signed [SEC_W-1:0]   whole_seconds = '0;
    logic signed [NANO_W-1:0]  nano_part = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [CHAR_W-1:0]         text_char;
    logic                      last_char;

    int fail_count;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asked     = 0;
    int hold_taken     = 0;
    int hold_left      = 0;
    int stuck_cycles   = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    duration_to_decimal_text dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_whole_seconds (whole_seconds),
        .i_nano_part     (nano_part),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_text_char     (text_char),
        .o_last_char     (last_char)
    );

    duration_to_decimal_text_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_whole_seconds (whole_seconds),
        .i_nano_part     (nano_part),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_text_char     (text_char),
        .i_last_char     (last_char),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_taken != hold_asked) begin
            out_ready  <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            hold_taken <= hold_asked;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Ends the run if neither channel moves a transaction for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                stuck_cycles <= 0;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("duration_to_decimal_text_test NOT OK");
                $finish;
            end
        end
    end

    task automatic offer_duration(input logic signed [SEC_W-1:0] secs,
                                  input logic signed [NANO_W-1:0] nanos);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid      <= 1'b1;
        whole_seconds <= secs;
        nano_part     <= nanos;
        do @(posedge clk); while (!in_ready);
    endtask

    // Sender pauses until every expected character has come back
    task automatic drain_text();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic logic [SEC_W-1:0] random_seconds();
        logic [SEC_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(3))
            0: begin
            end
            1: begin
                v = SEC_W'($urandom_range(1000));
                if ($urandom_range(1)) v = -v;
            end
            2: begin
                v = v >> $urandom_range(63);
                if ($urandom_range(1)) v = -v;
            end
            default: begin
                // near the ends of the range
                v = $urandom_range(1) ? {1'b1, {(SEC_W-1){1'b0}}} + SEC_W'($urandom_range(50))
                                      : {1'b0, {(SEC_W-1){1'b1}}} - SEC_W'($urandom_range(50));
            end
        endcase
        return v;
    endfunction

    function automatic logic [NANO_W-1:0] random_nanos();
        logic [NANO_W-1:0] v;
        int                pick;
        pick = $urandom_range(5);
        case (pick)
            0: v = '0;
            1: v = NANO_W'($urandom_range(1, 999) * 1000000);
            2: v = NANO_W'($urandom_range(1, 999999) * 1000);
            3: v = NANO_W'($urandom_range(1, 999999999));
            4: v = NANO_W'($urandom);
            default: v = dtdt_pkg::NANO_LIMIT - NANO_W'(2) + NANO_W'($urandom_range(4));
        endcase
        if (pick != 4 && $urandom_range(2) == 0) begin
            v = -v;
        end
        return v;
    endfunction

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase

            if (ph == 0) begin
                offer_duration(64'sd0, 31'sd0);
                offer_duration(64'sh7FFF_FFFF_FFFF_FFFF, 31'sd0);
                offer_duration(64'sh8000_0000_0000_0000, 31'sd0);
                offer_duration(-64'sd1, 31'sd0);
                offer_duration(64'sd0, 31'sd1);
                offer_duration(64'sd0, -31'sd1);
                offer_duration(64'sd5, 31'sd500000000);
                offer_duration(64'sd5, 31'sd500000);
                offer_duration(64'sd0, 31'sd1000);
                offer_duration(64'sd0, 31'sd1000000);
                offer_duration(64'sd1, 31'sd999999999);
                offer_duration(64'sd0, 31'sd123456789);
                offer_duration(-64'sd3, -31'sd250000000);
                offer_duration(64'sd3, -31'sd250000000);
                offer_duration(-64'sd3, 31'sd250000000);
                // nanoseconds beyond range saturate
                offer_duration(64'sd0, 31'sh3FFF_FFFF);
                offer_duration(64'sd0, 31'sh4000_0000);
                offer_duration(64'sd0, 31'sd1000000000);
                offer_duration(64'sd7, -31'sd1000000000);
                // longest text
                offer_duration(64'sh8000_0000_0000_0000, -31'sd999999999);
                offer_duration(64'sd10, 31'sd0);
                offer_duration(64'sd1000000000000000000, 31'sd10);
                offer_duration(-64'sd999999999999999999, 31'sd100);
                drain_text();

                // receiver holds off while the sender keeps offering
                hold_asked <= hold_asked + 1;
            end

            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                offer_duration(random_seconds(), random_nanos());
            end
            drain_text();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("duration_to_decimal_text_test OK");
        end else begin
            $display("duration_to_decimal_text_test NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/dtdt_pkg.sv
sv/duration_to_decimal_text.sv
sim/duration_to_decimal_text_checker.sv
sim/duration_to_decimal_text_test.sv
